>>> hdl/bmmp_pkg.sv
// ----------------------------------------------------------------------------
// bmmp_pkg: shared definitions for the prime-field Berlekamp-Massey unit
// Field constants, Barrett reduction constant, multiplier operation tags and
// the modular add helper used by the sequencer.
// ----------------------------------------------------------------------------
package bmmp_pkg;

	// Field and payload widths fixed by the interface.
	localparam int unsigned TERM_W      = 30;
	localparam int unsigned IDX_OUT_W   = 6;
	localparam int unsigned MAX_LEN_DEF = 32;

	localparam logic [TERM_W-1:0] PRIME = 30'd1000000007;

	// Fermat inverse exponent, scanned from the least significant bit.
	localparam int unsigned       INV_BITS = 30;
	localparam logic [TERM_W-1:0] INV_EXP  = PRIME - 30'd2;

	// Barrett constant floor(2^60 / PRIME); it fits in 31 bits.
	localparam logic [30:0] BARRETT_MU = 31'((64'd1 << 60) / 64'(PRIME));

	// Operation tags carried alongside each product.
	localparam logic [2:0] OP_DISC   = 3'd0;
	localparam logic [2:0] OP_INVACC = 3'd1;
	localparam logic [2:0] OP_INVSQ  = 3'd2;
	localparam logic [2:0] OP_QUOT   = 3'd3;
	localparam logic [2:0] OP_UPD    = 3'd4;

	typedef struct packed {
		logic [2:0]           kind;
		logic [IDX_OUT_W-1:0] idx;
		logic [TERM_W-1:0]    addend;
	} mm_aux_t;

	// Sum of two residues, reduced once.
	function automatic logic [TERM_W-1:0] add_mod(input logic [TERM_W-1:0] a,
			input logic [TERM_W-1:0] b);
		logic [TERM_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, PRIME}) begin
			s = s - {1'b0, PRIME};
		end
		return s[TERM_W-1:0];
	endfunction

endpackage

>>> hdl/bmmp_if.sv
// ----------------------------------------------------------------------------
// bmmp_if: channel interfaces of the Berlekamp-Massey unit
// A term channel into the block and a coefficient channel out of it, both
// with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface bmmp_term_if;
	import bmmp_pkg::*;

	logic              valid;
	logic              ready;
	logic [TERM_W-1:0] term;
	logic              final_term;

	modport source (output valid, output term, output final_term, input ready);
	modport sink   (input valid, input term, input final_term, output ready);
endinterface

interface bmmp_coef_if;
	import bmmp_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [IDX_OUT_W-1:0] coef_index;
	logic [TERM_W-1:0]    coef_value;
	logic [IDX_OUT_W-1:0] complexity;
	logic                 overflowed;
	logic                 final_coef;

	modport source (output valid, output coef_index, output coef_value,
		output complexity, output overflowed, output final_coef, input ready);
	modport sink   (input valid, input coef_index, input coef_value,
		input complexity, input overflowed, input final_coef, output ready);
endinterface

>>> hdl/bmmp_ram.sv
// ----------------------------------------------------------------------------
// bmmp_ram: generic single-write, single-read memory
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module bmmp_ram #(
	parameter int unsigned WIDTH = 30,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port, then registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
endmodule

>>> hdl/bmmp_poly_bank.sv
// ----------------------------------------------------------------------------
// bmmp_poly_bank: one polynomial store with per-entry valid flags
// An entry never written since the last clear reads as the polynomial one:
// the constant term is one and all others are zero.
// ----------------------------------------------------------------------------
module bmmp_poly_bank #(
	parameter int unsigned DEPTH = 33
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          clr,
	input  logic                          wr_en,
	input  logic [$clog2(DEPTH)-1:0]      wr_addr,
	input  logic [bmmp_pkg::TERM_W-1:0]   wr_data,
	input  logic                          rd_en,
	input  logic [$clog2(DEPTH)-1:0]      rd_addr,
	output logic [bmmp_pkg::TERM_W-1:0]   rd_data
);
	import bmmp_pkg::*;

	localparam int unsigned AW = $clog2(DEPTH);

	logic [DEPTH-1:0]  valid_q;
	logic              rd_vld_q;
	logic              rd_zero_q;
	logic [TERM_W-1:0] ram_rd;

	bmmp_ram #(.WIDTH(TERM_W), .DEPTH(DEPTH)) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (ram_rd)
	);

	// Valid flags: set on write, all cleared at once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			rd_vld_q  <= 1'b0;
			rd_zero_q <= 1'b0;
		end else begin
			if (clr) begin
				valid_q <= '0;
			end else if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q  <= valid_q[rd_addr];
				rd_zero_q <= (rd_addr == AW'(0));
			end
		end
	end

	// Unwritten entries take their reset value.
	assign rd_data = rd_vld_q ? ram_rd : (rd_zero_q ? TERM_W'(1) : '0);
endmodule

>>> hdl/bmmp_mulmod.sv
// ----------------------------------------------------------------------------
// bmmp_mulmod: pipelined modular multiplier
// Computes a*b mod PRIME in four stages by Barrett reduction and carries a
// tag alongside each product. One new operation may enter every cycle.
// ----------------------------------------------------------------------------
module bmmp_mulmod (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_v,
	input  logic [bmmp_pkg::TERM_W-1:0] in_a,
	input  logic [bmmp_pkg::TERM_W-1:0] in_b,
	input  bmmp_pkg::mm_aux_t           in_aux,
	output logic                        out_v,
	output logic [bmmp_pkg::TERM_W-1:0] out_r,
	output bmmp_pkg::mm_aux_t           out_aux
);
	import bmmp_pkg::*;

	logic          v_s1, v_s2, v_s3, v_s4;
	mm_aux_t       aux_s1, aux_s2, aux_s3, aux_s4;
	logic [59:0]   prod_s1;
	logic [30:0]   q_s2;
	logic [31:0]   plo_s2, plo_s3;
	logic [31:0]   qplo_s3;
	logic [TERM_W-1:0] res_s4;

	logic [59:0] prod_w;
	logic [61:0] qfull_w;
	logic [60:0] qp_w;
	logic [31:0] r0_w, r1_w, r2_w;

	assign prod_w  = in_a * in_b;
	assign qfull_w = prod_s1[59:29] * BARRETT_MU;
	assign qp_w    = q_s2 * PRIME;

	// Remainder is below four times the prime; two conditional subtracts.
	always_comb begin
		r0_w = plo_s3 - qplo_s3;
		r1_w = (r0_w >= 32'(2 * PRIME)) ? r0_w - 32'(2 * PRIME) : r0_w;
		r2_w = (r1_w >= 32'(PRIME)) ? r1_w - 32'(PRIME) : r1_w;
	end

	// Stage valids.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Datapath: product, quotient estimate, quotient times prime, remainder.
	always_ff @(posedge clk) begin
		prod_s1 <= prod_w;
		aux_s1  <= in_aux;
		q_s2    <= qfull_w[61:31];
		plo_s2  <= prod_s1[31:0];
		aux_s2  <= aux_s1;
		qplo_s3 <= qp_w[31:0];
		plo_s3  <= plo_s2;
		aux_s3  <= aux_s2;
		res_s4  <= r2_w[TERM_W-1:0];
		aux_s4  <= aux_s3;
	end

	assign out_v   = v_s4;
	assign out_r   = res_s4;
	assign out_aux = aux_s4;

	a_res_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		out_v |-> out_r < PRIME)
		else $error("modular product not fully reduced");
endmodule

>>> hdl/berlekamp_massey_mod_prime_unit.sv
// ----------------------------------------------------------------------------
// berlekamp_massey_mod_prime_unit: online Berlekamp-Massey over GF(1e9+7)
// Takes sequence terms one at a time and, on a term marked final, sends the
// connection polynomial coefficients C[0..L] out and starts afresh.
// ----------------------------------------------------------------------------
// Usage:
// term_ch carries one sequence term per transaction with a final flag. The
// block is ready only while idle; each term runs through one shared
// four-stage modular multiplier under the sequencer below.
// A term with zero discrepancy takes only the discrepancy sum over
// min(L,n) + 1 products. A nonzero discrepancy adds the Fermat inversion,
// a square-and-multiply step per exponent bit over 30 bits, then a quotient
// product and a 33-entry update sweep.
// Terms beyond MAX_LEN are dropped and flag overflow.
// On a final term coef_ch carries one transaction per coefficient, index 0
// first, each through the read, load and output states; a stalled
// receiver holds the output register and the block simply waits.
// After the last coefficient the state returns to its reset values.
// Asynchronous reset clears everything at once; no clearing pass.
// ----------------------------------------------------------------------------
module berlekamp_massey_mod_prime_unit #(
	parameter int unsigned MAX_LEN = bmmp_pkg::MAX_LEN_DEF
) (
	input logic              clk,
	input logic              arst_n,
	bmmp_term_if.sink        term_ch,
	bmmp_coef_if.source      coef_ch
);
	import bmmp_pkg::*;

	localparam int unsigned POLY_LEN = MAX_LEN + 1;
	localparam int unsigned IW       = $clog2(POLY_LEN);
	localparam int unsigned SW       = $clog2(MAX_LEN);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_DISC     = 4'd1;
	localparam logic [3:0] S_DWAIT    = 4'd2;
	localparam logic [3:0] S_INV_A    = 4'd3;
	localparam logic [3:0] S_INV_S    = 4'd4;
	localparam logic [3:0] S_INV_W    = 4'd5;
	localparam logic [3:0] S_QMUL     = 4'd6;
	localparam logic [3:0] S_QWAIT    = 4'd7;
	localparam logic [3:0] S_UPD      = 4'd8;
	localparam logic [3:0] S_UWAIT    = 4'd9;
	localparam logic [3:0] S_EMIT_RD  = 4'd10;
	localparam logic [3:0] S_EMIT_LD  = 4'd11;
	localparam logic [3:0] S_EMIT_OUT = 4'd12;

	logic [3:0]        state_q;
	logic [IW-1:0]     cnt_q, lim_q, n_q, len_q, count_q;
	logic [IW:0]       gap_q;
	logic [4:0]        bit_q;
	logic [3:0]        pend_q;
	logic              final_q, ovf_q, grow_q;
	logic [TERM_W-1:0] d_q, bd_q, x_q, inv_q, coefc_q;
	logic [1:0]        c_sel_q, b_sel_q, f_sel_q;

	logic              op_v_s1, op_bz_s1;
	logic [2:0]        op_kind_s1;
	logic [IW-1:0]     op_idx_s1;

	logic              out_v_q, out_final_q, out_ovf_q;
	logic [IDX_OUT_W-1:0] out_idx_q, out_len_q;
	logic [TERM_W-1:0] out_val_q;

	// Term intake.
	logic              accept;
	logic [TERM_W-1:0] s_red;
	logic              full;
	assign term_ch.ready = (state_q == S_IDLE);
	assign accept = term_ch.valid && term_ch.ready;
	assign s_red  = (term_ch.term >= PRIME) ? term_ch.term - PRIME : term_ch.term;
	assign full   = (count_q == IW'(MAX_LEN));

	// Operation issue towards the multiplier.
	logic       bit_last, issue;
	logic [2:0] issue_kind;
	assign bit_last = (bit_q == 5'(INV_BITS - 1));
	always_comb begin
		issue      = 1'b0;
		issue_kind = OP_DISC;
		case (state_q)
			S_DISC:  begin issue = 1'b1; issue_kind = OP_DISC; end
			S_INV_A: begin issue = INV_EXP[bit_q]; issue_kind = OP_INVACC; end
			S_INV_S: begin issue = !bit_last; issue_kind = OP_INVSQ; end
			S_QMUL:  begin issue = 1'b1; issue_kind = OP_QUOT; end
			S_UPD:   begin issue = 1'b1; issue_kind = OP_UPD; end
			default: begin issue = 1'b0; issue_kind = OP_DISC; end
		endcase
	end

	// Store addressing.
	logic [IW:0]   gap_diff;
	logic [IW-1:0] c_addr, b_addr;
	logic          k_below_gap;
	logic [SW-1:0] seq_rd_addr;
	assign gap_diff    = {1'b0, cnt_q} - gap_q;
	assign k_below_gap = ({1'b0, cnt_q} < gap_q);
	assign b_addr      = k_below_gap ? '0 : gap_diff[IW-1:0];
	assign c_addr      = cnt_q;
	assign seq_rd_addr = SW'(n_q - cnt_q);

	logic rd_active;
	assign rd_active = (state_q == S_DISC) || (state_q == S_UPD) || (state_q == S_EMIT_RD);

	// Sequence store.
	logic [TERM_W-1:0] seq_rd;
	bmmp_ram #(.WIDTH(TERM_W), .DEPTH(MAX_LEN)) u_seq (
		.clk     (clk),
		.wr_en   (accept && !full),
		.wr_addr (count_q[SW-1:0]),
		.wr_data (s_red),
		.rd_en   (state_q == S_DISC),
		.rd_addr (seq_rd_addr),
		.rd_data (seq_rd)
	);

	// Multiplier results.
	logic              mm_out_v;
	logic [TERM_W-1:0] mm_r;
	mm_aux_t           mm_aux;
	logic [TERM_W-1:0] upd_sum;
	logic              upd_wr;
	assign upd_sum = add_mod(mm_r, mm_aux.addend);
	assign upd_wr  = mm_out_v && (mm_aux.kind == OP_UPD);

	// Three polynomial banks whose roles rotate on a length change.
	logic [TERM_W-1:0] bank_rd [3];
	logic [1:0]        dst_sel;
	logic              bank_clr;
	assign dst_sel  = grow_q ? f_sel_q : c_sel_q;
	assign bank_clr = (state_q == S_EMIT_OUT) && coef_ch.ready && out_final_q;

	for (genvar g = 0; g < 3; g++) begin : g_bank
		bmmp_poly_bank #(.DEPTH(POLY_LEN)) u_bank (
			.clk     (clk),
			.arst_n  (arst_n),
			.clr     (bank_clr),
			.wr_en   (upd_wr && (dst_sel == 2'(g))),
			.wr_addr (mm_aux.idx[IW-1:0]),
			.wr_data (upd_sum),
			.rd_en   (rd_active),
			.rd_addr ((b_sel_q == 2'(g)) ? b_addr : c_addr),
			.rd_data (bank_rd[g])
		);
	end

	logic [TERM_W-1:0] c_rd, b_rd;
	assign c_rd = bank_rd[c_sel_q];
	assign b_rd = bank_rd[b_sel_q];

	// Operand selection in the cycle after issue, when memory data is ready.
	logic [TERM_W-1:0] mm_a, mm_b;
	mm_aux_t           mm_in_aux;
	always_comb begin
		mm_in_aux.kind   = op_kind_s1;
		mm_in_aux.idx    = IDX_OUT_W'(op_idx_s1);
		mm_in_aux.addend = c_rd;
		case (op_kind_s1)
			OP_DISC:   begin mm_a = c_rd;    mm_b = seq_rd; end
			OP_INVACC: begin mm_a = inv_q;   mm_b = x_q; end
			OP_INVSQ:  begin mm_a = x_q;     mm_b = x_q; end
			OP_QUOT:   begin mm_a = d_q;     mm_b = inv_q; end
			OP_UPD:    begin mm_a = coefc_q; mm_b = op_bz_s1 ? '0 : b_rd; end
			default:   begin mm_a = '0;      mm_b = '0; end
		endcase
	end

	bmmp_mulmod u_mulmod (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_v    (op_v_s1),
		.in_a    (mm_a),
		.in_b    (mm_b),
		.in_aux  (mm_in_aux),
		.out_v   (mm_out_v),
		.out_r   (mm_r),
		.out_aux (mm_aux)
	);

	// Next step after a term has been absorbed.
	logic [3:0] after_term;
	assign after_term = final_q ? S_EMIT_RD : S_IDLE;

	// Sequencer, scalar state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			lim_q       <= '0;
			n_q         <= '0;
			len_q       <= '0;
			count_q     <= '0;
			gap_q       <= (IW+1)'(1);
			bit_q       <= '0;
			pend_q      <= '0;
			final_q     <= 1'b0;
			ovf_q       <= 1'b0;
			grow_q      <= 1'b0;
			d_q         <= '0;
			bd_q        <= TERM_W'(1);
			x_q         <= '0;
			inv_q       <= '0;
			coefc_q     <= '0;
			c_sel_q     <= 2'd0;
			b_sel_q     <= 2'd1;
			f_sel_q     <= 2'd2;
			op_v_s1     <= 1'b0;
			op_bz_s1    <= 1'b0;
			op_kind_s1  <= OP_DISC;
			op_idx_s1   <= '0;
			out_v_q     <= 1'b0;
			out_final_q <= 1'b0;
			out_ovf_q   <= 1'b0;
			out_idx_q   <= '0;
			out_len_q   <= '0;
			out_val_q   <= '0;
		end else begin
			op_v_s1    <= issue;
			op_kind_s1 <= issue_kind;
			op_idx_s1  <= cnt_q;
			op_bz_s1   <= k_below_gap;
			pend_q     <= pend_q + 4'(issue) - 4'(mm_out_v);

			// Products coming back from the multiplier.
			if (mm_out_v) begin
				case (mm_aux.kind)
					OP_DISC:   d_q <= add_mod(d_q, mm_r);
					OP_INVACC: inv_q <= mm_r;
					OP_INVSQ:  x_q <= mm_r;
					OP_QUOT:   coefc_q <= (mm_r == '0) ? '0 : PRIME - mm_r;
					default:   ;
				endcase
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						final_q <= term_ch.final_term;
						cnt_q   <= '0;
						if (full) begin
							ovf_q <= 1'b1;
							if (term_ch.final_term) begin
								state_q <= S_EMIT_RD;
							end
						end else begin
							n_q     <= count_q;
							count_q <= count_q + IW'(1);
							lim_q   <= (len_q < count_q) ? len_q : count_q;
							d_q     <= '0;
							state_q <= S_DISC;
						end
					end
				end
				S_DISC: begin
					if (cnt_q == lim_q) begin
						state_q <= S_DWAIT;
					end else begin
						cnt_q <= cnt_q + IW'(1);
					end
				end
				S_DWAIT: begin
					if (pend_q == '0) begin
						if (d_q == '0) begin
							gap_q   <= gap_q + (IW+1)'(1);
							cnt_q   <= '0;
							state_q <= after_term;
						end else begin
							x_q     <= bd_q;
							inv_q   <= TERM_W'(1);
							bit_q   <= '0;
							state_q <= S_INV_A;
						end
					end
				end
				S_INV_A: state_q <= S_INV_S;
				S_INV_S: state_q <= S_INV_W;
				S_INV_W: begin
					if (pend_q == '0) begin
						if (bit_last) begin
							state_q <= S_QMUL;
						end else begin
							bit_q   <= bit_q + 5'd1;
							state_q <= S_INV_A;
						end
					end
				end
				S_QMUL: state_q <= S_QWAIT;
				S_QWAIT: begin
					if (pend_q == '0) begin
						cnt_q   <= '0;
						grow_q  <= ({len_q, 1'b0} <= {1'b0, n_q});
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					if (cnt_q == IW'(MAX_LEN)) begin
						state_q <= S_UWAIT;
					end else begin
						cnt_q <= cnt_q + IW'(1);
					end
				end
				S_UWAIT: begin
					if (pend_q == '0) begin
						cnt_q <= '0;
						if (grow_q) begin
							len_q   <= n_q + IW'(1) - len_q;
							bd_q    <= d_q;
							gap_q   <= (IW+1)'(1);
							c_sel_q <= f_sel_q;
							b_sel_q <= c_sel_q;
							f_sel_q <= b_sel_q;
						end else begin
							gap_q <= gap_q + (IW+1)'(1);
						end
						grow_q  <= 1'b0;
						state_q <= after_term;
					end
				end
				S_EMIT_RD: state_q <= S_EMIT_LD;
				S_EMIT_LD: begin
					out_v_q     <= 1'b1;
					out_idx_q   <= IDX_OUT_W'(cnt_q);
					out_val_q   <= c_rd;
					out_len_q   <= IDX_OUT_W'(len_q);
					out_ovf_q   <= ovf_q;
					out_final_q <= (cnt_q == len_q);
					state_q     <= S_EMIT_OUT;
				end
				S_EMIT_OUT: begin
					if (coef_ch.ready) begin
						out_v_q <= 1'b0;
						if (out_final_q) begin
							// Run complete: back to the reset state.
							cnt_q   <= '0;
							len_q   <= '0;
							count_q <= '0;
							gap_q   <= (IW+1)'(1);
							bd_q    <= TERM_W'(1);
							ovf_q   <= 1'b0;
							final_q <= 1'b0;
							c_sel_q <= 2'd0;
							b_sel_q <= 2'd1;
							f_sel_q <= 2'd2;
							state_q <= S_IDLE;
						end else begin
							cnt_q   <= cnt_q + IW'(1);
							state_q <= S_EMIT_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign coef_ch.valid      = out_v_q;
	assign coef_ch.coef_index = out_idx_q;
	assign coef_ch.coef_value = out_val_q;
	assign coef_ch.complexity = out_len_q;
	assign coef_ch.overflowed = out_ovf_q;
	assign coef_ch.final_coef = out_final_q;

	a_no_stray_result: assert property (@(posedge clk) disable iff (!arst_n)
		mm_out_v |-> pend_q != '0)
		else $error("multiplier result without an outstanding operation");

	a_idle_drained: assert property (@(posedge clk) disable iff (!arst_n)
		term_ch.ready |-> (pend_q == '0) && !op_v_s1)
		else $error("ready while products are still in flight");

	a_index_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		coef_ch.valid |-> coef_ch.coef_index <= coef_ch.complexity)
		else $error("coefficient index beyond the linear complexity");

	a_final_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		coef_ch.valid && coef_ch.final_coef |-> coef_ch.coef_index == coef_ch.complexity)
		else $error("final flag not on the highest coefficient");
endmodule

>>> test/bmmp_checker.sv
// ----------------------------------------------------------------------------
// bmmp_checker: coefficient predictor and scoreboard for the BM unit
// Watches the term and coefficient channels, runs its own Berlekamp-Massey
// over GF(1e9+7) on every accepted term up to MAX_LEN and compares each
// coefficient transaction with the oldest predicted one.
// ----------------------------------------------------------------------------
module bmmp_checker #(
	parameter int unsigned MAX_LEN = bmmp_pkg::MAX_LEN_DEF
) (
	input  logic clk,
	input  logic arst_n,
	bmmp_term_if term_ch,
	bmmp_coef_if coef_ch,
	output int   fail_count,
	output int   pending
);
	import bmmp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [IDX_OUT_W-1:0] idx;
		logic [TERM_W-1:0]    value;
		logic [IDX_OUT_W-1:0] cplx;
		logic                 ovf;
		logic                 last;
	} coef_t;

	localparam int unsigned PLEN = MAX_LEN + 1;

	coef_t coef_queue[$];

	logic [TERM_W-1:0] terms[MAX_LEN];
	logic [TERM_W-1:0] conn[PLEN];
	logic [TERM_W-1:0] prev[PLEN];
	int unsigned       lin_len;
	int unsigned       gap;
	logic [TERM_W-1:0] prev_disc;
	int unsigned       n_terms;
	logic              ovf_seen;

	function automatic logic [TERM_W-1:0] fmul(logic [TERM_W-1:0] a, logic [TERM_W-1:0] b);
		logic [63:0] p;
		p = 64'(a) * 64'(b);
		return TERM_W'(p % 64'(PRIME));
	endfunction

	function automatic logic [TERM_W-1:0] fadd(logic [TERM_W-1:0] a, logic [TERM_W-1:0] b);
		logic [31:0] s;
		s = 32'(a) + 32'(b);
		return TERM_W'(s % 32'(PRIME));
	endfunction

	function automatic logic [TERM_W-1:0] finv(logic [TERM_W-1:0] x);
		logic [TERM_W-1:0] acc;
		logic [TERM_W-1:0] e;
		acc = 1;
		e = PRIME - 30'd2;
		while (e != 0) begin
			if (e[0]) acc = fmul(acc, x);
			x = fmul(x, x);
			e = e >> 1;
		end
		return acc;
	endfunction

	task automatic clear_state();
		for (int i = 0; i < PLEN; i++) begin
			conn[i] = '0;
			prev[i] = '0;
		end
		conn[0] = 1;
		prev[0] = 1;
		lin_len = 0;
		gap = 1;
		prev_disc = 1;
		n_terms = 0;
		ovf_seen = 0;
	endtask

	// Folds one term into the connection polynomial.
	task automatic absorb_term(logic [TERM_W-1:0] s);
		logic [TERM_W-1:0] d;
		logic [TERM_W-1:0] c;
		logic [TERM_W-1:0] saved[PLEN];
		int unsigned       n;
		bit                grow;
		n = n_terms;
		d = 0;
		terms[n] = s;
		n_terms = n + 1;
		for (int unsigned i = 0; i <= lin_len && i <= n && i < PLEN; i++)
			d = fadd(d, fmul(conn[i], terms[n-i]));
		if (d == 0) begin
			gap++;
		end else begin
			c = fmul(d, finv(prev_disc));
			c = (c == 0) ? 30'd0 : PRIME - c;
			grow = (2 * lin_len <= n);
			saved = conn;
			for (int unsigned i = 0; i < PLEN; i++)
				if (i + gap < PLEN) conn[i+gap] = fadd(conn[i+gap], fmul(c, prev[i]));
			if (grow) begin
				lin_len = n + 1 - lin_len;
				prev = saved;
				prev_disc = d;
				gap = 1;
			end else begin
				gap++;
			end
		end
	endtask

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		$display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		pending = 0;
		clear_state();
	end

	// Term transactions: predict the coefficients a final term releases.
	always @(posedge clk) begin
		logic [TERM_W-1:0] s;
		int unsigned       lim;
		coef_t             r;
		if (arst_n && term_ch.valid && term_ch.ready) begin
			s = term_ch.term;
			if (s >= PRIME) s = s - PRIME;
			if (n_terms < MAX_LEN) absorb_term(s);
			else ovf_seen = 1;
			if (term_ch.final_term) begin
				lim = (lin_len > MAX_LEN) ? MAX_LEN : lin_len;
				for (int unsigned k = 0; k <= lim; k++) begin
					r.idx = IDX_OUT_W'(k);
					r.value = conn[k];
					r.cplx = IDX_OUT_W'(lim);
					r.ovf = ovf_seen;
					r.last = (k == lim);
					coef_queue.insert(coef_queue.size(), r);
				end
				clear_state();
				pending = coef_queue.size();
			end
		end
	end

	// Coefficient transactions: compare with the oldest prediction.
	always @(posedge clk) begin
		coef_t w;
		if (arst_n && coef_ch.valid && coef_ch.ready) begin
			if (coef_queue.size() == 0) begin
				$display("%0t coefficient with none predicted", $realtime);
				fail_count++;
			end else begin
				w = coef_queue.pop_front();
				pending = coef_queue.size();
				if (coef_ch.coef_index !== w.idx)
					report_mismatch("coef_index", coef_ch.coef_index, w.idx);
				if (coef_ch.coef_value !== w.value)
					report_mismatch("coef_value", coef_ch.coef_value, w.value);
				if (coef_ch.complexity !== w.cplx)
					report_mismatch("complexity", coef_ch.complexity, w.cplx);
				if (coef_ch.overflowed !== w.ovf)
					report_mismatch("overflowed", coef_ch.overflowed, w.ovf);
				if (coef_ch.final_coef !== w.last)
					report_mismatch("final_coef", coef_ch.final_coef, w.last);
			end
		end
	end

endmodule

>>> test/berlekamp_massey_mod_prime_unit_test.sv
// ----------------------------------------------------------------------------
// berlekamp_massey_mod_prime_unit_test: stimulus and verdict for the BM unit
// Sends directed and random sequences (recurrences, noise, overlong runs)
// with bursty input and a stalling receiver; the checker scores the output.
// ----------------------------------------------------------------------------
module berlekamp_massey_mod_prime_unit_test;
	import bmmp_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CAP      = MAX_LEN_DEF;
	localparam int          IDLE_MAX = 20000;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   idle_cycles;
	bit   long_hold;
	bit   hold_req;

	bmmp_term_if term_ch();
	bmmp_coef_if coef_ch();

	berlekamp_massey_mod_prime_unit u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.term_ch (term_ch),
		.coef_ch (coef_ch)
	);

	bmmp_checker #(.MAX_LEN(CAP)) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.term_ch    (term_ch),
		.coef_ch    (coef_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Watchdog on cycles without any transaction.
	always @(posedge clk) begin
		if ((term_ch.valid && term_ch.ready) || (coef_ch.valid && coef_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_MAX) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Receiver: its own stall pattern, plus one long hold-off on request.
	initial begin
		int mode;
		coef_ch.ready = 0;
		long_hold = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req && !long_hold) begin
				long_hold = 1;
				coef_ch.ready <= 0;
				repeat (3000) @(negedge clk);
			end
			mode = $urandom_range(0, 9);
			if (mode < 3) coef_ch.ready <= 1;
			else if (mode < 8) coef_ch.ready <= $urandom_range(0, 1);
			else coef_ch.ready <= 0;
		end
	end

	int burst_left;

	// Sends one term; gaps between bursts of random length. Valid stays high
	// after the transaction so that the next term can follow directly.
	task automatic send_term(logic [TERM_W-1:0] t, logic fin);
		int gap_len;
		if (burst_left == 0) begin
			gap_len = $urandom_range(0, 6);
			if (gap_len != 0) begin
				term_ch.valid <= 0;
				repeat (gap_len) @(negedge clk);
			end
			burst_left = $urandom_range(1, 8);
		end
		term_ch.valid <= 1;
		term_ch.term <= t;
		term_ch.final_term <= fin;
		@(posedge clk);
		while (!term_ch.ready) @(posedge clk);
		@(negedge clk);
		burst_left--;
	endtask

	function automatic logic [TERM_W-1:0] rand_res();
		return TERM_W'($urandom_range(0, 1000000006));
	endfunction

	// A sequence obeying a random recurrence of order ord, length len.
	task automatic send_recurrence(int ord, int len);
		logic [TERM_W-1:0] a[CAP];
		logic [TERM_W-1:0] h[64];
		logic [63:0]       acc;
		for (int i = 0; i < ord; i++) begin
			a[i] = rand_res();
			h[i] = rand_res();
		end
		for (int i = ord; i < len; i++) begin
			acc = 0;
			for (int j = 0; j < ord; j++)
				acc = (acc + 64'(a[j]) * 64'(h[i-1-j])) % 64'(PRIME);
			h[i] = TERM_W'(acc);
		end
		for (int i = 0; i < len; i++) send_term(h[i], i == len - 1);
	endtask

	initial begin
		int len;
		int kind;
		term_ch.valid = 0;
		term_ch.term = '0;
		term_ch.final_term = 0;
		hold_req = 0;
		idle_cycles = 0;
		burst_left = 0;
		arst_n = 0;
		repeat (10) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed: extremes, out-of-range terms, zero runs, overflow.
		send_term('0, 1);
		send_term(PRIME - 1, 1);
		send_term({TERM_W{1'b1}}, 1);
		send_term(PRIME, 0);
		send_term(PRIME + 30'd5, 1);
		send_term(30'd1, 0);
		send_term(30'd1, 0);
		send_term(30'd2, 0);
		send_term(30'd3, 1);
		send_term('0, 0);
		send_term('0, 0);
		send_term(30'd7, 1);
		for (int i = 0; i < CAP + 3; i++) send_term(rand_res(), i == CAP + 2);

		// Sender pause until everything has drained.
		term_ch.valid <= 0;
		burst_left = 0;
		while (pending != 0) @(negedge clk);
		repeat (20) @(negedge clk);

		// Long receiver hold-off while terms keep coming.
		hold_req = 1;
		for (int s = 0; s < 3; s++) send_recurrence(2, 6);
		hold_req = 0;

		// Random part: mostly recurrences, some noise and overlong runs.
		for (int sent = 0; sent < 500; sent += len) begin
			kind = $urandom_range(0, 9);
			if (kind < 6) begin
				len = $urandom_range(1, 12);
				send_recurrence($urandom_range(1, (len + 1) / 2), len);
			end else if (kind < 9) begin
				len = $urandom_range(1, 10);
				for (int i = 0; i < len; i++)
					send_term(TERM_W'($urandom), i == len - 1);
			end else begin
				len = $urandom_range(CAP - 1, CAP + 3);
				send_recurrence($urandom_range(1, 16), len);
			end
		end

		term_ch.valid <= 0;
		while (pending != 0) @(negedge clk);
		repeat (300) @(negedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

>>> sim.f
hdl/bmmp_pkg.sv
hdl/bmmp_if.sv
hdl/bmmp_ram.sv
hdl/bmmp_poly_bank.sv
hdl/bmmp_mulmod.sv
hdl/berlekamp_massey_mod_prime_unit.sv
test/bmmp_checker.sv
test/berlekamp_massey_mod_prime_unit_test.sv
